>>> src/page_run_allocator_assert.svh
// Assertion macros for the page run allocator checker.
// Depends on nothing; included by the checker file.
`ifndef PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define PAGE_RUN_ALLOCATOR_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define PRA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`endif

>>> src/pra_pkg.sv
// Shared types and codes for the page run allocator.
// No dependencies.
package pra_pkg;
  typedef enum logic [2:0] {
    FN_ALLOC = 3'd0, FN_FREE = 3'd1, FN_RESV = 3'd2, FN_SETTAG = 3'd3, FN_GETTAG = 3'd4
  } func_e;
  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ZERO = 3'd1, ST_BIG = 3'd2, ST_ALIGN = 3'd3, ST_NOSPACE = 3'd4,
    ST_NOTALLOC = 3'd5, ST_CORRUPT = 3'd6, ST_NULL = 3'd7
  } status_e;
  typedef enum logic [1:0] {PG_FREE = 2'd0, PG_USED = 2'd1, PG_RESV = 2'd2} pstate_e;
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SRD, S_SCAN, S_FILL, S_FRD, S_FREE, S_RRD, S_RESV, S_TRD, S_TAG,
    S_CLR, S_STRD, S_STAT, S_OUT
  } fsm_e;
  localparam logic [0:0] REG_BASE = 1'b0;
  localparam logic [0:0] REG_KTAG = 1'b1;
endpackage

>>> src/pra_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> src/page_run_allocator.sv
// Page run allocator: first-fit contiguous page allocator, one request at a time.
// Each request runs a sequencer over the page table held in one RAM (pra_ram).
// After reset a clearing pass marks all pages free; no item is taken meanwhile.
// Every request ends with a statistics sweep over all pages. Before that, an
// allocation searches first fit for a run, reading and then examining each page,
// and fills it one page at a time; a reserve reads every page and writes those in
// range; a free reads and clears each page of the run.
// Uses pra_pkg and pra_ram.
module page_run_allocator #(
  parameter int PAGE_COUNT = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [31:0] address_i,
  input  logic [31:0] end_address_i,
  input  logic [31:0] size_bytes_i,
  input  logic [31:0] align_bytes_i,
  input  logic [31:0] tag_in_i,
  input  logic        kernel_flag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] result_address_o,
  output logic [31:0] tag_out_o,
  output logic [8:0]  used_pages_o,
  output logic [8:0]  free_pages_o,
  output logic [8:0]  reserved_pages_o,
  output logic [8:0]  largest_free_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int AW = $clog2(PAGE_COUNT);
  localparam int CW = AW + 1;
  localparam int EW = 2 + CW + 32 + 1;
  localparam logic [63:0] PBYTES = 64'd1 << PAGE_SHIFT;
  localparam logic [CW-1:0] PCNT = CW'(PAGE_COUNT);

  pra_pkg::fsm_e state_q, state_d;
  logic [31:0] base_q, ktag_q;
  logic [2:0] func_q;
  logic [31:0] addr_q, align_q, tag_q;
  logic kern_q;
  logic [CW-1:0] need_q, need_d;
  logic [CW-1:0] idx_q, idx_d, cand_q, cand_d, cnt_q, cnt_d;
  logic [CW-1:0] used_q, used_d, free_q, free_d, resv_q, resv_d, run_q, run_d, best_q, best_d;
  logic [2:0] st_q, st_d;
  logic [31:0] raddr_q, raddr_d, tago_q, tago_d;
  logic [63:0] paddr_q, paddr_d, lim_q;
  logic [63:0] s_q, e_q;
  logic [AW:0] pg_q;
  logic pg_hit_q;
  logic done_q, done_d;

  logic we;
  logic [AW-1:0] ra;
  logic [EW-1:0] wd, rd;
  logic [1:0] r_st;
  logic [CW-1:0] r_run;
  logic [31:0] r_tag;

  pra_ram #(.Width(EW), .Depth(1 << AW)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(ra), .wdata_i(wd), .rdata_o(rd)
  );
  assign r_st = rd[EW-1 -: 2];
  assign r_run = rd[EW-3 -: CW];
  assign r_tag = rd[32:1];

  assign in_stall_o = (state_q != pra_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (state_q == pra_pkg::S_OUT);
  assign status_o = st_q;
  assign result_address_o = raddr_q;
  assign tag_out_o = tago_q;
  assign used_pages_o = 9'(used_q);
  assign free_pages_o = 9'(free_q);
  assign reserved_pages_o = 9'(resv_q);
  assign largest_free_run_o = 9'(best_q);

  logic [63:0] off;
  logic [32:0] need_w;
  assign off = {32'd0, addr_q} - {32'd0, base_q};
  assign need_w = ({1'b0, size_bytes_i} + 33'(PBYTES - 64'd1)) >> PAGE_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pra_pkg::S_CLR;
      base_q <= '0;
      ktag_q <= '0;
      idx_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      done_q <= done_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == pra_pkg::REG_BASE) base_q <= cfg_data_i;
        else ktag_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d; cand_q <= cand_d; cnt_q <= cnt_d;
    used_q <= used_d; free_q <= free_d; resv_q <= resv_d; run_q <= run_d; best_q <= best_d;
    st_q <= st_d; raddr_q <= raddr_d; tago_q <= tago_d; paddr_q <= paddr_d;
    if (state_q == pra_pkg::S_IDLE && in_valid_i) begin
      func_q <= func_i; addr_q <= address_i;
      align_q <= align_bytes_i; tag_q <= tag_in_i; kern_q <= kernel_flag_i;
      s_q <= {32'd0, address_i} & ~(PBYTES - 64'd1);
      e_q <= ({32'd0, end_address_i} + PBYTES - 64'd1) & ~(PBYTES - 64'd1);
      lim_q <= {32'd0, align_bytes_i} - 64'd1;
    end
    if (state_q == pra_pkg::S_CHECK) begin
      pg_hit_q <= (addr_q >= base_q) && (off[63:PAGE_SHIFT] < 64'(PAGE_COUNT));
      pg_q <= (AW+1)'(off[63:PAGE_SHIFT]);
    end
  end

  always_comb begin
    state_d = state_q; idx_d = idx_q; done_d = done_q;
    need_d = need_q; cand_d = cand_q; cnt_d = cnt_q;
    used_d = used_q; free_d = free_q; resv_d = resv_q; run_d = run_q; best_d = best_q;
    st_d = st_q; raddr_d = raddr_q; tago_d = tago_q; paddr_d = paddr_q;
    we = 1'b0; ra = idx_q[AW-1:0]; wd = '0;
    unique case (state_q)
      pra_pkg::S_CLR: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == PCNT - 1'b1) state_d = pra_pkg::S_IDLE;
      end
      pra_pkg::S_IDLE: begin
        if (in_valid_i) begin
          st_d = pra_pkg::ST_OK; raddr_d = '0; tago_d = '0;
          idx_d = '0; cand_d = '0; cnt_d = '0;
          need_d = (need_w > 33'(PAGE_COUNT)) ? '0 : CW'(need_w);
          state_d = pra_pkg::S_CHECK;
          if (func_i == pra_pkg::FN_ALLOC) begin
            if (size_bytes_i == '0) st_d = pra_pkg::ST_ZERO;
            else if (align_bytes_i == '0 || (align_bytes_i & (align_bytes_i - 1)) != '0)
              st_d = pra_pkg::ST_ALIGN;
            else if (need_w > 33'(PAGE_COUNT)) st_d = pra_pkg::ST_BIG;
          end
        end
      end
      pra_pkg::S_CHECK: begin
        paddr_d = {32'd0, base_q};
        idx_d = '0;
        case (func_q)
          pra_pkg::FN_ALLOC:
            state_d = (st_q == pra_pkg::ST_OK) ? pra_pkg::S_SRD : pra_pkg::S_STRD;
          pra_pkg::FN_RESV: state_d = pra_pkg::S_RRD;
          pra_pkg::FN_FREE, pra_pkg::FN_SETTAG, pra_pkg::FN_GETTAG:
            state_d = (addr_q == '0) ? pra_pkg::S_STRD : pra_pkg::S_TRD;
          default: state_d = pra_pkg::S_STRD;
        endcase
        if (addr_q == '0 && (func_q == pra_pkg::FN_FREE || func_q == pra_pkg::FN_SETTAG ||
            func_q == pra_pkg::FN_GETTAG)) st_d = pra_pkg::ST_NULL;
      end
      // allocation search: cand is run start, cnt free pages seen so far
      pra_pkg::S_SRD: begin
        if (({1'b0, cand_q} + {1'b0, need_q}) > {1'b0, PCNT}) begin
          st_d = pra_pkg::ST_NOSPACE; idx_d = '0; state_d = pra_pkg::S_STRD;
        end else if (cnt_q == '0 && align_q > 32'(PBYTES) && (paddr_q & lim_q) != '0) begin
          cand_d = cand_q + 1'b1; idx_d = cand_q + 1'b1; paddr_d = paddr_q + PBYTES;
        end else if (cnt_q == need_q) begin
          idx_d = cand_q; cnt_d = '0; raddr_d = paddr_q[31:0]; state_d = pra_pkg::S_FILL;
        end else begin
          ra = idx_q[AW-1:0]; state_d = pra_pkg::S_SCAN;
        end
      end
      // a busy page rules out every start up to and including it
      pra_pkg::S_SCAN: begin
        if (r_st == pra_pkg::PG_FREE) begin
          cnt_d = cnt_q + 1'b1; idx_d = idx_q + 1'b1;
        end else begin
          cnt_d = '0; cand_d = idx_q + 1'b1; idx_d = idx_q + 1'b1;
          paddr_d = {32'd0, base_q} + (64'(idx_q + 1'b1) << PAGE_SHIFT);
        end
        state_d = pra_pkg::S_SRD;
      end
      pra_pkg::S_FILL: begin
        we = 1'b1;
        wd = {pra_pkg::PG_USED, (cnt_q == '0) ? need_q : CW'(0), tag_q, kern_q};
        idx_d = idx_q + 1'b1; cnt_d = cnt_q + 1'b1;
        if (cnt_q + 1'b1 == need_q) begin idx_d = '0; state_d = pra_pkg::S_STRD; end
      end
      pra_pkg::S_TRD: begin
        if (!pg_hit_q) begin
          st_d = pra_pkg::ST_NOTALLOC; idx_d = '0; state_d = pra_pkg::S_STRD;
        end else begin
          ra = pg_q[AW-1:0]; idx_d = CW'(pg_q); state_d = pra_pkg::S_TAG;
        end
      end
      pra_pkg::S_TAG: begin
        ra = idx_q[AW-1:0];
        state_d = pra_pkg::S_STRD;
        if (func_q == pra_pkg::FN_GETTAG) tago_d = r_tag;
        else if (r_st != pra_pkg::PG_USED) st_d = pra_pkg::ST_NOTALLOC;
        else if (func_q == pra_pkg::FN_SETTAG) begin
          we = 1'b1; wd = {r_st, r_run, tag_q, rd[0]};
        end else if (r_run == '0 || idx_q + r_run > PCNT) st_d = pra_pkg::ST_CORRUPT;
        else begin
          need_d = r_run; cnt_d = '0; state_d = pra_pkg::S_FRD;
        end
        if (state_d == pra_pkg::S_STRD) idx_d = '0;
      end
      pra_pkg::S_FRD: begin
        if (cnt_q == need_q) begin idx_d = '0; state_d = pra_pkg::S_STRD; end
        else state_d = pra_pkg::S_FREE;
      end
      pra_pkg::S_FREE: begin
        if (r_st != pra_pkg::PG_USED) begin
          st_d = pra_pkg::ST_CORRUPT; idx_d = '0; state_d = pra_pkg::S_STRD;
        end else begin
          we = 1'b1; wd = '0;
          idx_d = idx_q + 1'b1; cnt_d = cnt_q + 1'b1; state_d = pra_pkg::S_FRD;
        end
      end
      pra_pkg::S_RRD: state_d = pra_pkg::S_RESV;
      pra_pkg::S_RESV: begin
        if (paddr_q >= s_q && paddr_q < e_q) begin
          we = 1'b1; wd = {pra_pkg::PG_RESV, r_run, ktag_q, 1'b1};
        end
        paddr_d = paddr_q + PBYTES;
        idx_d = idx_q + 1'b1;
        state_d = pra_pkg::S_RRD;
        if (idx_q == PCNT - 1'b1) begin idx_d = '0; state_d = pra_pkg::S_STRD; end
      end
      pra_pkg::S_STRD: begin
        used_d = '0; free_d = '0; resv_d = '0; run_d = '0; best_d = '0;
        done_d = 1'b0; state_d = pra_pkg::S_STAT; idx_d = '0;
      end
      pra_pkg::S_STAT: begin
        ra = idx_q[AW-1:0];
        if (done_q) begin
          if (r_st == pra_pkg::PG_FREE) begin
            free_d = free_q + 1'b1; run_d = run_q + 1'b1;
            if (run_q + 1'b1 > best_q) best_d = run_q + 1'b1;
          end else begin
            run_d = '0;
            if (r_st == pra_pkg::PG_USED) used_d = used_q + 1'b1;
            else resv_d = resv_q + 1'b1;
          end
          if (idx_q == PCNT) state_d = pra_pkg::S_OUT;
        end
        done_d = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q < PCNT) ra = idx_q[AW-1:0];
      end
      pra_pkg::S_OUT: if (!out_stall_i) begin state_d = pra_pkg::S_IDLE; idx_d = '0; end
      default: state_d = pra_pkg::S_IDLE;
    endcase
    if (state_q == pra_pkg::S_SCAN || state_q == pra_pkg::S_FILL ||
        state_q == pra_pkg::S_FREE || state_q == pra_pkg::S_RESV ||
        state_q == pra_pkg::S_CLR) ra = idx_q[AW-1:0];
    if (state_q == pra_pkg::S_FRD || state_q == pra_pkg::S_RRD) ra = idx_q[AW-1:0];
  end
endmodule

>>> src/pra_checker.sv
// Port-level checker for the page run allocator, bound to the top level.
// Depends on page_run_allocator_assert.svh.
`include "page_run_allocator_assert.svh"
module pra_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [8:0] used_pages_o,
  input logic [8:0] free_pages_o,
  input logic [8:0] reserved_pages_o,
  input logic [8:0] largest_free_run_o
);
  `PRA_ASSERT(a_busy_out, clk_i, rst_ni, out_valid_o |-> in_stall_o)
  `PRA_ASSERT(a_sum, clk_i, rst_ni,
    out_valid_o |-> (12'(used_pages_o) + 12'(free_pages_o) + 12'(reserved_pages_o) != 12'd0))
  `PRA_ASSERT(a_run, clk_i, rst_ni, out_valid_o |-> largest_free_run_o <= free_pages_o)
  `PRA_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)
endmodule

bind page_run_allocator pra_checker u_pra_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for page_run_allocator: random and directed page requests,
// predicted by an in-bench page table model and compared per result item.
// Depends on pra_pkg and the page_run_allocator RTL.
module tb_top;

  localparam int NPAGES     = 256;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] addr;
    logic [31:0] end_addr;
    logic [31:0] size;
    logic [31:0] align;
    logic [31:0] tag;
    logic        kflag;
  } page_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] raddr;
    logic [31:0] tag;
    logic [8:0]  used;
    logic [8:0]  freec;
    logic [8:0]  resv;
    logic [8:0]  run;
  } page_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  page_req_t   cur_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  page_rsp_t   got;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = pra_pkg::REG_BASE;
  logic [31:0] cfg_data = '0;

  page_req_t pending_ops[$];
  page_rsp_t expected_rsp[$];
  int        errors = 0;
  int        mode = 0;
  logic      in_took = 1'b0;
  logic      hold_tog = 1'b0;
  logic      hold_seen = 1'b0;
  int        hold_left = 0;
  int        idle_cnt = 0;

  // page table model
  logic [31:0]      m_base = '0;
  logic [31:0]      m_ktag = '0;
  pra_pkg::pstate_e m_st[NPAGES];
  int               m_len[NPAGES];
  logic [31:0]      m_tag[NPAGES];
  logic             m_kern[NPAGES];

  always #10 clk = ~clk;

  page_run_allocator i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(cur_req.func), .address_i(cur_req.addr), .end_address_i(cur_req.end_addr),
    .size_bytes_i(cur_req.size), .align_bytes_i(cur_req.align),
    .tag_in_i(cur_req.tag), .kernel_flag_i(cur_req.kflag),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(got.status), .result_address_o(got.raddr), .tag_out_o(got.tag),
    .used_pages_o(got.used), .free_pages_o(got.freec),
    .reserved_pages_o(got.resv), .largest_free_run_o(got.run),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic int page_of(logic [31:0] a);
    logic [31:0] off;
    if (a < m_base) return NPAGES;
    off = (a - m_base) >> 12;
    if (off >= NPAGES) return NPAGES;
    return int'(off);
  endfunction

  task automatic apply_page_op(input page_req_t r, output page_rsp_t o);
    logic [63:0] sz, al, need, pa, s, e;
    int i, j, pg, n;
    logic found, fits, stop;
    o = '0;
    o.status = pra_pkg::ST_OK;
    case (r.func)
      pra_pkg::FN_ALLOC: begin
        sz = {32'b0, r.size};
        al = {32'b0, r.align};
        if (sz == 0) o.status = pra_pkg::ST_ZERO;
        else if (al == 0 || (al & (al - 1)) != 0) o.status = pra_pkg::ST_ALIGN;
        else begin
          need = (sz + 64'hFFF) >> 12;
          if (need > NPAGES) o.status = pra_pkg::ST_BIG;
          else begin
            o.status = pra_pkg::ST_NOSPACE;
            found = 1'b0;
            for (i = 0; i + need <= NPAGES && !found; i++) begin
              pa = {32'b0, m_base} + (64'(i) << 12);
              if (al > 64'h1000 && (pa & (al - 1)) != 0) continue;
              fits = 1'b1;
              for (j = 0; j < int'(need); j++)
                if (m_st[i + j] != pra_pkg::PG_FREE) fits = 1'b0;
              if (fits) begin
                for (j = 0; j < int'(need); j++) begin
                  m_st[i + j] = pra_pkg::PG_USED;
                  m_len[i + j] = (j == 0) ? int'(need) : 0;
                  m_tag[i + j] = r.tag;
                  m_kern[i + j] = r.kflag;
                end
                o.raddr = pa[31:0];
                o.status = pra_pkg::ST_OK;
                found = 1'b1;
              end
            end
          end
        end
      end
      pra_pkg::FN_FREE: begin
        if (r.addr == 0) o.status = pra_pkg::ST_NULL;
        else begin
          pg = page_of(r.addr);
          if (pg >= NPAGES || m_st[pg] != pra_pkg::PG_USED) o.status = pra_pkg::ST_NOTALLOC;
          else begin
            n = m_len[pg];
            if (n == 0 || pg + n > NPAGES) o.status = pra_pkg::ST_CORRUPT;
            else begin
              stop = 1'b0;
              for (j = 0; j < n && !stop; j++) begin
                if (m_st[pg + j] != pra_pkg::PG_USED) begin
                  o.status = pra_pkg::ST_CORRUPT;
                  stop = 1'b1;
                end else begin
                  m_st[pg + j] = pra_pkg::PG_FREE;
                  m_len[pg + j] = 0;
                  m_tag[pg + j] = '0;
                  m_kern[pg + j] = 1'b0;
                end
              end
            end
          end
        end
      end
      pra_pkg::FN_RESV: begin
        s = {32'b0, r.addr} & ~64'hFFF;
        e = ({32'b0, r.end_addr} + 64'hFFF) & ~64'hFFF;
        for (i = 0; i < NPAGES; i++) begin
          pa = {32'b0, m_base} + (64'(i) << 12);
          if (pa >= s && pa < e) begin
            m_st[i] = pra_pkg::PG_RESV;
            m_tag[i] = m_ktag;
            m_kern[i] = 1'b1;
          end
        end
      end
      pra_pkg::FN_SETTAG: begin
        if (r.addr == 0) o.status = pra_pkg::ST_NULL;
        else begin
          pg = page_of(r.addr);
          if (pg >= NPAGES || m_st[pg] != pra_pkg::PG_USED) o.status = pra_pkg::ST_NOTALLOC;
          else m_tag[pg] = r.tag;
        end
      end
      pra_pkg::FN_GETTAG: begin
        if (r.addr == 0) o.status = pra_pkg::ST_NULL;
        else begin
          pg = page_of(r.addr);
          if (pg >= NPAGES) o.status = pra_pkg::ST_NOTALLOC;
          else o.tag = m_tag[pg];
        end
      end
      default: ;
    endcase
    n = 0;
    for (i = 0; i < NPAGES; i++) begin
      if (m_st[i] == pra_pkg::PG_FREE) begin
        o.freec++;
        n++;
        if (n > o.run) o.run = 9'(n);
      end else begin
        n = 0;
        if (m_st[i] == pra_pkg::PG_USED) o.used++;
        else o.resv++;
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] g, input logic [31:0] x);
    $display("mismatch %s: got %h expected %h", what, g, x);
    errors++;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pending_ops.size() > 0 &&
          $urandom_range(0, 99) >= (mode == 0 ? 22 : (mode == 1 ? 79 : 0))) begin
        cur_req <= pending_ops.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with the long hold-off counted here
  always @(negedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < (mode == 0 ? 79 : (mode == 1 ? 22 : 0));
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    page_rsp_t exp_r;
    in_took <= in_valid && !in_stall;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == pra_pkg::REG_BASE) m_base = cfg_data;
      else m_ktag = cfg_data;
    end
    if (in_valid && !in_stall) begin
      apply_page_op(cur_req, exp_r);
      expected_rsp.push_back(exp_r);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) report("unexpected item", 32'b0, 32'b0);
      else begin
        exp_r = expected_rsp.pop_front();
        if (got.status !== exp_r.status) report("status", 32'(got.status), 32'(exp_r.status));
        if (got.raddr !== exp_r.raddr) report("result_address", got.raddr, exp_r.raddr);
        if (got.tag !== exp_r.tag) report("tag_out", got.tag, exp_r.tag);
        if (got.used !== exp_r.used) report("used_pages", 32'(got.used), 32'(exp_r.used));
        if (got.freec !== exp_r.freec) report("free_pages", 32'(got.freec), 32'(exp_r.freec));
        if (got.resv !== exp_r.resv) report("reserved_pages", 32'(got.resv), 32'(exp_r.resv));
        if (got.run !== exp_r.run) report("largest_free_run", 32'(got.run), 32'(exp_r.run));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_op(input pra_pkg::func_e f, input logic [31:0] a, input logic [31:0] ea,
                         input logic [31:0] sz, input logic [31:0] al,
                         input logic [31:0] t, input logic kf);
    page_req_t r;
    r.func = f; r.addr = a; r.end_addr = ea; r.size = sz; r.align = al;
    r.tag = t; r.kflag = kf;
    pending_ops.push_back(r);
  endtask

  task automatic wait_drained();
    wait (pending_ops.size() == 0 && !in_valid && expected_rsp.size() == 0);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_addr(input logic want_head, input logic want_used);
    int k, p;
    for (k = 0; k < 16; k++) begin
      p = $urandom_range(0, NPAGES - 1);
      if ((m_st[p] == pra_pkg::PG_USED || !want_used) && (!want_head || m_len[p] != 0))
        return m_base + 32'(p) * 32'h1000 + $urandom_range(0, 4095);
    end
    if ($urandom_range(0, 19) == 0) return $urandom;
    return m_base + 32'($urandom_range(0, 300)) * 32'h1000 + $urandom_range(0, 4095);
  endfunction

  function automatic page_req_t make_item();
    page_req_t r;
    logic [223:0] raw;
    int roll;
    r.func = pra_pkg::FN_ALLOC;
    r.addr = '0;
    r.end_addr = $urandom;
    r.size = '0;
    r.align = '0;
    r.tag = $urandom;
    r.kflag = $urandom_range(0, 1);
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      r.size = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8 * 4096)
                                            : $urandom_range(1, 64 * 4096);
      r.align = ($urandom_range(0, 99) < 70) ? (32'd1 << $urandom_range(0, 12))
                                             : (32'd1 << $urandom_range(13, 20));
      r.addr = $urandom;
    end else if (roll < 70) begin
      r.func = pra_pkg::FN_FREE;
      r.addr = pick_addr(1'b1, 1'b1);
    end else if (roll < 80) begin
      r.func = pra_pkg::FN_SETTAG;
      r.addr = pick_addr(1'b0, 1'b1);
    end else if (roll < 90) begin
      r.func = pra_pkg::FN_GETTAG;
      r.addr = pick_addr(1'b0, 1'b0);
    end else if (roll < 92) begin
      r.func = pra_pkg::FN_RESV;
      r.addr = m_base + 32'($urandom_range(0, 270)) * 32'h1000 + $urandom_range(0, 4095);
      r.end_addr = r.addr + $urandom_range(0, 2 * 4096);
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(page_req_t)-1:0];
      if (r.func == pra_pkg::FN_RESV) r.end_addr = r.addr & ~32'hFFF;
    end
    return r;
  endfunction

  initial begin
    logic [31:0] bases[6];
    logic [31:0] ktags[6];
    int ph, k, b;
    for (k = 0; k < NPAGES; k++) begin
      m_st[k] = pra_pkg::PG_FREE; m_len[k] = 0; m_tag[k] = '0; m_kern[k] = 1'b0;
    end
    bases = '{32'h0, 32'h8000_0000, 32'hFFFF_F000, 32'h0001_2345, 32'hFFFF_FFFF,
              32'h0040_0000};
    ktags = '{32'hFFFF_FFFF, $urandom, 32'h0, $urandom, 32'hA5A5_5A5A, $urandom};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      mode = ph % 3;
      write_reg(pra_pkg::REG_BASE, bases[ph]);
      write_reg(pra_pkg::REG_KTAG, ktags[ph]);
      if (ph == 0) begin
        push_op(pra_pkg::FN_ALLOC, 0, 0, 0, 4096, 0, 0);
        push_op(pra_pkg::FN_ALLOC, 0, 0, 100, 0, 0, 0);
        push_op(pra_pkg::FN_ALLOC, 0, 0, 100, 3, 0, 0);
        push_op(pra_pkg::FN_ALLOC, 0, 0, 32'hFFFF_FFFF, 4096, 0, 0);
        push_op(pra_pkg::FN_ALLOC, 0, 0, 1, 1, 32'hFFFF_FFFF, 1);
        push_op(pra_pkg::FN_ALLOC, 0, 0, 32'h3001, 32'h1_0000, 32'h1234_5678, 0);
        push_op(pra_pkg::FN_ALLOC, 0, 0, 256 * 4096, 4096, 0, 0);
        push_op(pra_pkg::FN_ALLOC, 0, 0, 4096, 32'h8000_0000, 0, 1);
        push_op(pra_pkg::FN_GETTAG, 0, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_FREE, 0, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_SETTAG, 0, 0, 0, 0, 32'hDEAD_BEEF, 0);
        push_op(pra_pkg::FN_GETTAG, 32'h1000, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_SETTAG, 32'h1_0010, 0, 0, 0, 32'hCAFE_0001, 0);
        push_op(pra_pkg::FN_SETTAG, 32'h1000, 0, 0, 0, 32'h5, 0);
        push_op(pra_pkg::FN_GETTAG, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_FREE, 32'h1_1000, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_RESV, 32'h1_2000, 32'h1_2001, 0, 0, 0, 0);
        push_op(pra_pkg::FN_FREE, 32'h1_0000, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_FREE, 32'h1_0000, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_FREE, 32'h1_2345, 0, 0, 0, 0, 0);
        push_op(pra_pkg::FN_RESV, 32'hF_F000, 32'hFFFF_FFFF, 0, 0, 0, 0);
        push_op(pra_pkg::FN_RESV, 32'h0, 32'h0, 0, 0, 0, 0);
        push_op(pra_pkg::func_e'(3'd5), 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        push_op(pra_pkg::func_e'(3'd7), 0, 0, 0, 0, 0, 1);
        wait_drained();
      end
      if (ph == 1) hold_tog = ~hold_tog;
      for (b = 0; b < 24; b++) begin
        wait (pending_ops.size() == 0);
        for (k = 0; k < 8; k++) pending_ops.push_back(make_item());
      end
    end
    wait_drained();
    repeat (1000) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
